### hdl/pdga_pkg.sv
package pdga_pkg;

   localparam int GRID_X     = 64;
   localparam int GRID_Z     = 64;
   localparam int CELL_SHIFT = 10;
   localparam int MAX_POINTS = 4096;

   localparam int NCELLS = GRID_X * GRID_Z;
   localparam int CELL_W = $clog2(NCELLS);
   localparam int CX_W   = $clog2(GRID_X);
   localparam int CZ_W   = $clog2(GRID_Z);
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   // opcodes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SEED  = 2'd1;
   localparam logic [1:0] OP_TEST  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_ACCEPT  = 3'd0;
   localparam logic [2:0] ST_BOUNDS  = 3'd1;
   localparam logic [2:0] ST_CLOSE   = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_CLEARED = 3'd4;

   // register indexes (byte address = 8 * index)
   localparam logic [1:0] REG_MIN_DIST_SQ = 2'd0;
   localparam logic [1:0] REG_X_LIMIT     = 2'd1;
   localparam logic [1:0] REG_Z_LIMIT     = 2'd2;

   typedef logic [IDX_W:0] cell_entry_type;   // {valid, point index}

   function automatic logic [CX_W-1:0] cell_x(input logic [15:0] v);
      logic [15:0] c;
      c = v >> CELL_SHIFT;
      if (c >= 16'(GRID_X - 1)) begin
         return CX_W'(GRID_X - 1);
      end
      return CX_W'(c);
   endfunction

   function automatic logic [CZ_W-1:0] cell_z(input logic [15:0] v);
      logic [15:0] c;
      c = v >> CELL_SHIFT;
      if (c >= 16'(GRID_Z - 1)) begin
         return CZ_W'(GRID_Z - 1);
      end
      return CZ_W'(c);
   endfunction

   function automatic logic [CELL_W-1:0] cell_addr(input logic [CX_W-1:0] i,
                                                    input logic [CZ_W-1:0] j);
      return CELL_W'(CELL_W'(i) * CELL_W'(GRID_Z) + CELL_W'(j));
   endfunction

endpackage

### hdl/poisson_disk_grid_accept_top.sv
// Poisson disk acceptance test and insertion over a background cell grid.
// Input stream (req_): one transaction per command {opcode, cand_x, cand_z}.
//   clear empties the grid and the point count; seed stores a point with no
//   test; test checks the open bounds, the store fill, then the 5x5 cell
//   neighborhood (clamped at the grid edges) against min_dist_sq.
// Result stream (rsp_): exactly one transaction per command {status, index}.
// Configuration: APB-style registers min_dist_sq (0x00), x_limit (0x08),
//   z_limit (0x10); write only while the block is idle.
// Timing: one command at a time. A test scans one cell per cycle through the
//   cell memory, the point memory and a two-stage squaring/compare pipe;
//   bounds/full rejects and seeds skip the scan. Clear sweeps the cell
//   memory one entry per cycle. req_tready rises in the same cycle that the
//   result shows up.
// Reset: the same sweep runs with req_tready low.
// A stalled result sits in the output register; the next command is taken
//   meanwhile and only waits for that register before it is written back.
module poisson_disk_grid_accept_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // [1:0] opcode, [17:2] cand_x, [33:18] cand_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [2:0] status, [14:3] point_index
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam int CW = pdga_pkg::CX_W;
   localparam int ZW = pdga_pkg::CZ_W;
   localparam int AW = pdga_pkg::CELL_W;
   localparam int IW = pdga_pkg::IDX_W;
   localparam int NW = pdga_pkg::CNT_W;

   // configuration
   logic [32:0] min_dist_sq_ff;
   logic [15:0] x_limit_ff;
   logic [15:0] z_limit_ff;
   logic        csr_wr;

   // control
   logic [2:0]    state_ff;
   logic [AW-1:0] sweep_ff;
   logic          clr_rsp_ff;
   logic [NW-1:0] count_ff;
   logic          rsp_valid_ff;
   logic          s1_ff, s2_ff, s3_ff;

   // payload
   logic [1:0]    op_ff;
   logic [15:0]   cand_x_ff, cand_z_ff;
   logic [CW-1:0] x0_ff, x1_ff, i_ff;
   logic [ZW-1:0] z0_ff, z1_ff, j_ff;
   logic [AW-1:0] ins_cell_ff;
   logic          hit_ff;
   logic [2:0]    res_status_ff;
   logic          do_ins_ff;
   logic [2:0]    rsp_status_ff;
   logic [11:0]   rsp_index_ff;
   logic [31:0]   dx2_ff, dz2_ff;

   // memories
   pdga_pkg::cell_entry_type cell_mem [pdga_pkg::NCELLS];
   logic [31:0]              point_mem [pdga_pkg::MAX_POINTS];
   pdga_pkg::cell_entry_type cm_q_ff;
   logic [31:0]              ps_q_ff;

   logic                     out_free;
   logic                     ins_fire;
   logic                     cm_we;
   logic [AW-1:0]            cm_waddr;
   pdga_pkg::cell_entry_type cm_wdata;
   logic [AW-1:0]            scan_addr;

   logic [CW-1:0] cx;
   logic [ZW-1:0] cz;
   logic [CW:0]   cx_hi;
   logic [ZW:0]   cz_hi;
   logic          out_of_bounds;
   logic          store_full;
   logic [15:0]   dx, dz;
   logic [15:0]   px, pz;
   logic [32:0]   dist_sq;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_sq_ff <= 33'd65536;
         x_limit_ff     <= 16'hFFFF;
         z_limit_ff     <= 16'hFFFF;
      end else if (csr_wr) begin
         case (csr_paddr[4:3])
            pdga_pkg::REG_MIN_DIST_SQ: min_dist_sq_ff <= csr_pwdata[32:0];
            pdga_pkg::REG_X_LIMIT:     x_limit_ff     <= csr_pwdata[15:0];
            pdga_pkg::REG_Z_LIMIT:     z_limit_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         pdga_pkg::REG_MIN_DIST_SQ: csr_prdata = {31'd0, min_dist_sq_ff};
         pdga_pkg::REG_X_LIMIT:     csr_prdata = {48'd0, x_limit_ff};
         pdga_pkg::REG_Z_LIMIT:     csr_prdata = {48'd0, z_limit_ff};
         default:                   csr_prdata = 64'd0;
      endcase
   end

   // ---------------- combinational helpers ----------------
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_index_ff, rsp_status_ff};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ins_fire = (state_ff == S_FINISH) && out_free && do_ins_ff;

   assign cx    = pdga_pkg::cell_x(cand_x_ff);
   assign cz    = pdga_pkg::cell_z(cand_z_ff);
   assign cx_hi = {1'b0, cx} + (CW + 1)'(2);
   assign cz_hi = {1'b0, cz} + (ZW + 1)'(2);

   assign out_of_bounds = (cand_x_ff >= x_limit_ff) || (cand_z_ff >= z_limit_ff) ||
                          (cand_x_ff == 16'd0) || (cand_z_ff == 16'd0);
   assign store_full    = (count_ff >= NW'(pdga_pkg::MAX_POINTS));

   assign scan_addr = pdga_pkg::cell_addr(i_ff, j_ff);

   assign cm_we    = (state_ff == S_CLEAR) || ins_fire;
   assign cm_waddr = (state_ff == S_CLEAR) ? sweep_ff : ins_cell_ff;
   assign cm_wdata = (state_ff == S_CLEAR) ? '0 : {1'b1, IW'(count_ff)};

   assign px = ps_q_ff[15:0];
   assign pz = ps_q_ff[31:16];
   assign dx = (px > cand_x_ff) ? px - cand_x_ff : cand_x_ff - px;
   assign dz = (pz > cand_z_ff) ? pz - cand_z_ff : cand_z_ff - pz;
   assign dist_sq = {1'b0, dx2_ff} + {1'b0, dz2_ff};

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (cm_we) begin
         cell_mem[cm_waddr] <= cm_wdata;
      end
      cm_q_ff <= cell_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (ins_fire) begin
         point_mem[IW'(count_ff)] <= {cand_z_ff, cand_x_ff};
      end
      ps_q_ff <= point_mem[cm_q_ff[IW-1:0]];
   end

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         s3_ff        <= 1'b0;
      end else begin
         s1_ff <= (state_ff == S_SCAN);
         s2_ff <= s1_ff && cm_q_ff[IW];
         s3_ff <= s2_ff;
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (sweep_ff == AW'(pdga_pkg::NCELLS - 1)) begin
                  sweep_ff   <= '0;
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= clr_rsp_ff ? S_FINISH : S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (op_ff == pdga_pkg::OP_CLEAR) begin
                  count_ff   <= '0;
                  clr_rsp_ff <= 1'b1;
                  state_ff   <= S_CLEAR;
               end else if (op_ff == pdga_pkg::OP_SEED || out_of_bounds || store_full) begin
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (i_ff == x1_ff && j_ff == z1_ff) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!s1_ff && !s2_ff && !s3_ff) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  if (do_ins_ff) begin
                     count_ff <= count_ff + NW'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      dx2_ff <= 32'(dx * dx);
      dz2_ff <= 32'(dz * dz);
      if (s3_ff && dist_sq <= min_dist_sq_ff) begin
         hit_ff <= 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_ff     <= req_tdata[1:0];
               cand_x_ff <= req_tdata[17:2];
               cand_z_ff <= req_tdata[33:18];
            end
         end
         S_CHECK: begin
            hit_ff      <= 1'b0;
            ins_cell_ff <= pdga_pkg::cell_addr(cx, cz);
            x0_ff       <= (cx >= CW'(2)) ? cx - CW'(2) : '0;
            z0_ff       <= (cz >= ZW'(2)) ? cz - ZW'(2) : '0;
            x1_ff       <= (cx_hi > (CW + 1)'(pdga_pkg::GRID_X - 1)) ?
                           CW'(pdga_pkg::GRID_X - 1) : CW'(cx_hi);
            z1_ff       <= (cz_hi > (ZW + 1)'(pdga_pkg::GRID_Z - 1)) ?
                           ZW'(pdga_pkg::GRID_Z - 1) : ZW'(cz_hi);
            i_ff        <= (cx >= CW'(2)) ? cx - CW'(2) : '0;
            j_ff        <= (cz >= ZW'(2)) ? cz - ZW'(2) : '0;
            do_ins_ff   <= (op_ff == pdga_pkg::OP_SEED) && !store_full;
            if (op_ff == pdga_pkg::OP_CLEAR) begin
               res_status_ff <= pdga_pkg::ST_CLEARED;
            end else if (op_ff == pdga_pkg::OP_SEED) begin
               res_status_ff <= store_full ? pdga_pkg::ST_FULL : pdga_pkg::ST_ACCEPT;
            end else if (out_of_bounds) begin
               res_status_ff <= pdga_pkg::ST_BOUNDS;
            end else if (store_full) begin
               res_status_ff <= pdga_pkg::ST_FULL;
            end
         end
         S_SCAN: begin
            if (i_ff == x1_ff) begin
               i_ff <= x0_ff;
               j_ff <= j_ff + ZW'(1);
            end else begin
               i_ff <= i_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            if (!s1_ff && !s2_ff && !s3_ff) begin
               res_status_ff <= hit_ff ? pdga_pkg::ST_CLOSE : pdga_pkg::ST_ACCEPT;
               do_ins_ff     <= !hit_ff;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_status_ff <= res_status_ff;
               rsp_index_ff  <= do_ins_ff ? 12'(count_ff) : 12'd0;
            end
         end
         default: ;
      endcase
   end

endmodule

### tb/tb_top.sv
module tb_top;

   localparam int GRID_X     = pdga_pkg::GRID_X;
   localparam int GRID_Z     = pdga_pkg::GRID_Z;
   localparam int CELL_SHIFT = pdga_pkg::CELL_SHIFT;
   localparam int MAX_POINTS = pdga_pkg::MAX_POINTS;
   localparam int NCELLS     = pdga_pkg::NCELLS;
   localparam int IDX_W      = pdga_pkg::IDX_W;

   // opcode 3 has no command of its own; the block treats it as a test
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 400;

   typedef struct packed {
      logic [2:0]       status;
      logic [IDX_W-1:0] index;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;     // [1:0] opcode, [17:2] cand_x, [33:18] cand_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [2:0] status, [14:3] point_index
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   poisson_disk_grid_accept_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // grid model: registers, cells, stored points
   logic [32:0]      cfg_min_dist = 33'd65536;
   logic [15:0]      cfg_x_lim = 16'd65535;
   logic [15:0]      cfg_z_lim = 16'd65535;
   bit               cell_used [NCELLS];
   logic [IDX_W-1:0] cell_owner [NCELLS];
   logic [31:0]      point_xz [MAX_POINTS];
   int unsigned      stored_count = 0;

   outcome_type pending_outcomes[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_reqs = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic int unsigned grid_cell(input logic [15:0] v, input int unsigned grid);
      int unsigned c;
      c = v >> CELL_SHIFT;
      if (c > grid - 1) c = grid - 1;
      return c;
   endfunction

   function automatic bit neighbor_in_radius(input logic [15:0] x, input logic [15:0] z);
      int unsigned      cx, cz, lo_x, hi_x, lo_z, hi_z, cell_id;
      longint unsigned  dx, dz, px, pz;
      logic [31:0]      p;
      cx = grid_cell(x, GRID_X);
      cz = grid_cell(z, GRID_Z);
      lo_x = (cx >= 2) ? cx - 2 : 0;
      lo_z = (cz >= 2) ? cz - 2 : 0;
      hi_x = (cx + 2 > GRID_X - 1) ? GRID_X - 1 : cx + 2;
      hi_z = (cz + 2 > GRID_Z - 1) ? GRID_Z - 1 : cz + 2;
      for (int unsigned j = lo_z; j <= hi_z; j++) begin
         for (int unsigned i = lo_x; i <= hi_x; i++) begin
            cell_id = i * GRID_Z + j;
            if (cell_used[cell_id]) begin
               p = point_xz[cell_owner[cell_id]];
               px = p[15:0];
               pz = p[31:16];
               dx = (px > x) ? px - x : x - px;
               dz = (pz > z) ? pz - z : z - pz;
               if (dx * dx + dz * dz <= longint'(cfg_min_dist)) return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [IDX_W-1:0] store_point(input logic [15:0] x, input logic [15:0] z);
      int unsigned cell_id;
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(stored_count);
      cell_id = grid_cell(x, GRID_X) * GRID_Z + grid_cell(z, GRID_Z);
      point_xz[idx] = {z, x};
      cell_owner[cell_id] = idx;
      cell_used[cell_id] = 1'b1;
      stored_count++;
      return idx;
   endfunction

   function automatic outcome_type predict_outcome(input logic [1:0] op, input logic [15:0] x,
                                                   input logic [15:0] z);
      outcome_type o;
      o.index = '0;
      if (op == pdga_pkg::OP_CLEAR) begin
         foreach (cell_used[k]) cell_used[k] = 1'b0;
         stored_count = 0;
         o.status = pdga_pkg::ST_CLEARED;
      end else if (op == pdga_pkg::OP_SEED) begin
         if (stored_count >= MAX_POINTS) begin
            o.status = pdga_pkg::ST_FULL;
         end else begin
            o.index = store_point(x, z);
            o.status = pdga_pkg::ST_ACCEPT;
         end
      end else begin
         // opcode 3 falls here too: handled as a test
         if (x >= cfg_x_lim || z >= cfg_z_lim || x == 0 || z == 0) begin
            o.status = pdga_pkg::ST_BOUNDS;
         end else if (stored_count >= MAX_POINTS) begin
            o.status = pdga_pkg::ST_FULL;
         end else if (neighbor_in_radius(x, z)) begin
            o.status = pdga_pkg::ST_CLOSE;
         end else begin
            o.index = store_point(x, z);
            o.status = pdga_pkg::ST_ACCEPT;
         end
      end
      return o;
   endfunction

   task automatic enqueue_outcome(input outcome_type o);
      pending_outcomes = {pending_outcomes, o};
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch: %s got %0d want %0d", what, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      outcome_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[2:0];
         got.index = rsp_tdata[3 +: IDX_W];
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result status", 16'(got.status), 16'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 16'(got.status), 16'(want.status));
            if (got.index !== want.index)
               report_mismatch("point_index", 16'(got.index), 16'(want.index));
         end
      end
   end

   // receiver: random stalls plus long hold-off on request
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic send_cmd(input logic [1:0] op, input logic [15:0] x, input logic [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, z, x, op};
      do @(posedge clock); while (!req_tready);
      enqueue_outcome(predict_outcome(op, x, z));
   endtask

   // wait until every result is back, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] reg_id, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_id, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (reg_id)
         pdga_pkg::REG_MIN_DIST_SQ: cfg_min_dist = value[32:0];
         pdga_pkg::REG_X_LIMIT:     cfg_x_lim = value[15:0];
         pdga_pkg::REG_Z_LIMIT:     cfg_z_lim = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [32:0] radius_sq, input logic [15:0] xl,
                            input logic [15:0] zl);
      settle();
      write_csr(pdga_pkg::REG_MIN_DIST_SQ, 64'(radius_sq));
      write_csr(pdga_pkg::REG_X_LIMIT, 64'(xl));
      write_csr(pdga_pkg::REG_Z_LIMIT, 64'(zl));
   endtask

   function automatic logic [15:0] clamp_coord(input int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return 16'(v);
   endfunction

   function automatic logic [15:0] edge_coord(input logic [15:0] lim);
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'd1;
         2: return lim - 16'd1;
         3: return lim;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic pick_candidate(input bit allow_clear, output logic [1:0] op,
                                 output logic [15:0] x, output logic [15:0] z);
      int unsigned r, mode, spread;
      logic [31:0] p;
      r = $urandom_range(999);
      if (allow_clear && r < 15) op = pdga_pkg::OP_CLEAR;
      else if (r < 165) op = pdga_pkg::OP_SEED;
      else if (r < 245) op = OP_SPARE;
      else op = pdga_pkg::OP_TEST;
      mode = $urandom_range(9);
      if (mode <= 3 && stored_count > 0) begin
         // near a stored point, so the radius test is exercised
         p = point_xz[$urandom_range(stored_count - 1)];
         case ($urandom_range(2))
            0: spread = 300;
            1: spread = 1200;
            default: spread = 3000;
         endcase
         x = clamp_coord(int'(p[15:0]) + int'($urandom_range(2 * spread)) - int'(spread));
         z = clamp_coord(int'(p[31:16]) + int'($urandom_range(2 * spread)) - int'(spread));
      end else if (mode <= 6) begin
         x = 16'(20000 + $urandom_range(4095));
         z = 16'(20000 + $urandom_range(4095));
      end else if (mode <= 8) begin
         x = 16'($urandom());
         z = 16'($urandom());
      end else begin
         x = edge_coord(cfg_x_lim);
         z = $urandom_range(1) ? edge_coord(cfg_z_lim) : 16'($urandom());
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_cmd(pdga_pkg::OP_TEST, 16'd1, 16'd1);
      send_cmd(pdga_pkg::OP_TEST, 16'd0, 16'd500);
      send_cmd(pdga_pkg::OP_TEST, 16'd500, 16'd0);
      send_cmd(pdga_pkg::OP_TEST, 16'hFFFF, 16'd500);
      send_cmd(pdga_pkg::OP_TEST, 16'd500, 16'hFFFF);
      send_cmd(pdga_pkg::OP_TEST, 16'hFFFE, 16'hFFFE);
      send_cmd(OP_SPARE, 16'd30000, 16'd30000);
      send_cmd(pdga_pkg::OP_TEST, 16'd30000, 16'd30000);
      // exactly on the radius: rejected
      send_cmd(pdga_pkg::OP_TEST, 16'd30256, 16'd30000);
      send_cmd(pdga_pkg::OP_TEST, 16'd30000, 16'd30257);
      send_cmd(pdga_pkg::OP_TEST, 16'd30128, 16'd30128);
      send_cmd(pdga_pkg::OP_SEED, 16'd0, 16'd0);
      send_cmd(pdga_pkg::OP_SEED, 16'hFFFF, 16'hFFFF);
      // same cell as an earlier point: cell entry is replaced
      send_cmd(pdga_pkg::OP_SEED, 16'd30100, 16'd30600);
      send_cmd(pdga_pkg::OP_TEST, 16'd30000, 16'd30300);
      send_cmd(pdga_pkg::OP_TEST, 16'd2, 16'd2);
      send_cmd(OP_SPARE, 16'hFFFE, 16'hFFFD);
      send_cmd(pdga_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
      send_cmd(pdga_pkg::OP_TEST, 16'd1, 16'd1);
      send_cmd(pdga_pkg::OP_TEST, 16'd1, 16'd1);
      settle();
   endtask

   task automatic test_limits();
      write_all(33'd0, 16'd1, 16'd1);
      send_cmd(pdga_pkg::OP_TEST, 16'd1, 16'd1);
      send_cmd(pdga_pkg::OP_TEST, 16'd0, 16'd0);
      send_cmd(OP_SPARE, 16'd500, 16'd500);
      send_cmd(pdga_pkg::OP_SEED, 16'd500, 16'd500);
      write_all(33'd0, 16'hFFFF, 16'hFFFF);
      send_cmd(pdga_pkg::OP_TEST, 16'd500, 16'd500);
      send_cmd(pdga_pkg::OP_TEST, 16'd501, 16'd500);
      write_all(33'h1_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(pdga_pkg::OP_TEST, 16'd1500, 16'd1500);
      send_cmd(pdga_pkg::OP_TEST, 16'd40000, 16'd40000);
      send_cmd(pdga_pkg::OP_TEST, 16'd42100, 16'd40000);
      send_cmd(pdga_pkg::OP_TEST, 16'd43100, 16'd40000);
      write_all(33'd1000000, 16'd20000, 16'd10000);
      send_cmd(pdga_pkg::OP_TEST, 16'd19999, 16'd9999);
      send_cmd(pdga_pkg::OP_TEST, 16'd20000, 16'd5000);
      send_cmd(pdga_pkg::OP_TEST, 16'd5000, 16'd10000);
      write_all(33'd65536, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_backpressure();
      logic [1:0]  op;
      logic [15:0] x, z;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_reqs++;
      repeat (48) begin
         pick_candidate(1'b0, op, x, z);
         send_cmd(op, x, z);
      end
      settle();
   endtask

   task automatic test_random_phases();
      logic [1:0]  op;
      logic [15:0] x, z;
      logic [32:0] radius_sq;
      logic [15:0] xl, zl;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         case ($urandom_range(4))
            0: radius_sq = 33'd0;
            1: radius_sq = 33'd65536;
            2: radius_sq = 33'h1_FFFF_FFFF;
            3: radius_sq = 33'($urandom_range(1, 4000000));
            default: radius_sq = {1'($urandom()), 32'($urandom())};
         endcase
         xl = ($urandom_range(9) < 7) ? 16'hFFFF : 16'($urandom_range(1000, 65535));
         zl = ($urandom_range(9) < 7) ? 16'hFFFF : 16'($urandom_range(1000, 65535));
         write_all(radius_sq, xl, zl);
         repeat (PHASE_ITEMS) begin
            pick_candidate(1'b1, op, x, z);
            send_cmd(op, x, z);
         end
      end
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_backpressure();
      test_random_phases();
      settle();
      repeat (40) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch("results missing", 16'd0, 16'(pending_outcomes.size()));
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
